>>> src/recorder_frame_deframer_assert.svh
// Assertion macros for the recorder frame deframer.
// Needs clk and rst_n in the scope of each use.
`ifndef RECORDER_FRAME_DEFRAMER_ASSERT_SVH
`define RECORDER_FRAME_DEFRAMER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define RFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the recorder frame deframer.
// No dependencies.
package rfd_pkg;

    localparam int WIN_BYTES_DEF = 24;

    // header marker characters
    localparam logic [7:0] CH_D    = 8'h64;  // 'd'
    localparam logic [7:0] CH_C    = 8'h63;  // 'c'
    localparam logic [7:0] CH_H    = 8'h48;  // 'H'
    localparam logic [7:0] CH_2    = 8'h32;  // '2'
    localparam logic [7:0] CH_3    = 8'h33;  // '3'
    localparam logic [7:0] CH_W    = 8'h77;  // 'w'
    localparam logic [7:0] CH_B    = 8'h62;  // 'b'
    localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE  = 8'h31;  // '1'

    localparam logic [16:0] VID_HDR_BASE = 17'd24;
    localparam logic [16:0] AUD_HDR_LEN  = 17'd8;
    localparam logic [32:0] PAD_ADD      = 33'd7;
    localparam logic [32:0] PAD_MASK     = ~33'd7;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic KIND_HDR     = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam logic [2:0] FT_I     = 3'd1;
    localparam logic [2:0] FT_P     = 3'd2;
    localparam logic [2:0] FT_OTHER = 3'd3;
    localparam logic [2:0] FT_AUDIO = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [2:0]  media_type;
        logic [63:0] media_time;
        logic [32:0] payload_length;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic        run_last;
    } res_t;

endpackage

>>> src/recorder_frame_deframer.sv
`timescale 1ns / 1ps
// Recorder frame deframer: top level, one module.
// Uses rfd_pkg and the assertion macros of recorder_frame_deframer_assert.svh.
//
// Usage
//   Input channel (in_valid/in_stall): req_type 0 carries one stream byte in
//   data_byte, req_type 1 drains the window at end of stream.
//   Output channel (out_valid/out_stall): one item per header found
//   (kind 0) and per payload byte (kind 1); run_last marks the last item
//   caused by one input item.
//   Byte items: one accepted per cycle while in_stall is low; each gives at
//   most one result, which is registered in the output register or the skid
//   entry. The leaving byte and the full window are classified in the cycle
//   the 24th byte arrives. Drain items: the held bytes (up to 23) leave one
//   per cycle while the skid entry is empty; in_stall is high meanwhile.
//   Results sit in an output register backed by one skid entry, so input
//   keeps flowing while a single result waits; a second waiting result
//   raises in_stall until the receiver takes one.
//   Reset empties the window and the output buffer and returns to search.
`include "recorder_frame_deframer_assert.svh"

module recorder_frame_deframer #(
    parameter int WINDOW_BYTES = rfd_pkg::WIN_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [2:0]  media_type,
    output logic [63:0] media_time,
    output logic [32:0] payload_length,
    output logic [7:0]  payload_byte,
    output logic        frame_last,
    output logic        run_last
);
    import rfd_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_BYTES - 1);

    // window storage and frame tracking state
    logic [7:0]       win_reg  [WINDOW_BYTES];
    logic [7:0]       win_next [WINDOW_BYTES];
    logic [7:0]       hw       [WINDOW_BYTES];  // window as seen with the new byte on top
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic             drain_reg, drain_next;
    logic             in_frame_reg, in_frame_next;
    logic [32:0]      pos_reg, pos_next;
    logic [32:0]      total_reg, total_next;
    logic [32:0]      plen_reg, plen_next;
    logic [16:0]      hl_reg, hl_next;
    logic [2:0]       type_reg, type_next;
    logic [63:0]      time_reg, time_next;

    // output buffer
    res_t out_reg, skid_reg, res;
    logic out_valid_reg, skid_valid_reg, res_valid;

    logic acc, byte_acc, drain_acc, byte_pop, drain_pop;
    logic is_video, is_audio, hdr_hit;
    logic [31:0] raw_len;
    logic [32:0] pad_len, hdr_total;
    logic [16:0] hdr_hl;
    logic [63:0] hdr_time;
    logic [2:0]  hdr_type;
    logic        last_pos, more;
    logic [33:0] q_pos, tot_m1, q_min;

    assign in_stall  = drain_reg || skid_valid_reg;
    assign acc       = in_valid && !in_stall;
    assign byte_acc  = acc && (req_type == REQ_BYTE);
    assign drain_acc = acc && (req_type == REQ_DRAIN);
    assign byte_pop  = byte_acc && (fill_reg == LAST_IDX);
    assign drain_pop = drain_reg && !skid_valid_reg;

    always_comb
    begin
        for (int i = 0; i < WINDOW_BYTES - 1; i++)
        begin
            hw[i] = win_reg[i];
        end
        hw[WINDOW_BYTES-1] = data_byte;
    end

    // header decode on the full window; fixed byte offsets of the format
    always_comb
    begin
        is_video = (hw[2] == CH_D) && (hw[3] == CH_C) && (hw[4] == CH_H) && (hw[5] == CH_2);
        is_audio = (hw[1] == CH_3) && (hw[2] == CH_W) && (hw[3] == CH_B);
        hdr_hit  = is_video || is_audio;
        if (is_video)
        begin
            raw_len = {hw[11], hw[10], hw[9], hw[8]};
            hdr_hl  = {1'b0, hw[13], hw[12]} + VID_HDR_BASE;
            for (int k = 0; k < 8; k++)
            begin
                hdr_time[8*k +: 8] = hw[16 + k];
            end
            if (hw[1] == CH_ZERO)
                hdr_type = FT_I;
            else if (hw[1] == CH_ONE)
                hdr_type = FT_P;
            else
                hdr_type = FT_OTHER;
        end
        else
        begin
            raw_len  = {16'd0, hw[7], hw[6]};
            hdr_hl   = AUD_HDR_LEN;
            hdr_time = time_reg;
            hdr_type = FT_AUDIO;
        end
        pad_len   = ({1'b0, raw_len} + PAD_ADD) & PAD_MASK;
        hdr_total = pad_len + {16'd0, hdr_hl};
    end

    // in-frame bookkeeping; "more" tells whether a later drain pop still
    // yields a payload byte, which decides run_last on a drain
    always_comb
    begin
        last_pos = ({1'b0, pos_reg} + 34'd1) >= {1'b0, total_reg};
        q_pos    = {1'b0, pos_reg} + 34'(fill_reg) - 34'd1;
        tot_m1   = {1'b0, total_reg} - 34'd1;
        q_min    = (q_pos < tot_m1) ? q_pos : tot_m1;
        more     = !last_pos && (fill_reg > IDX_W'(1)) && (q_min >= 34'(hl_reg));
    end

    always_comb
    begin
        win_next      = win_reg;
        fill_next     = fill_reg;
        drain_next    = drain_reg;
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        plen_next     = plen_reg;
        hl_next       = hl_reg;
        type_next     = type_reg;
        time_next     = time_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (byte_acc && !byte_pop)
        begin
            win_next[fill_reg] = data_byte;
            fill_next          = fill_reg + IDX_W'(1);
        end
        if (drain_acc && (fill_reg != '0))
            drain_next = 1'b1;

        if (byte_pop || drain_pop)
        begin
            // shift the window down by one
            for (int i = 0; i < WINDOW_BYTES - 1; i++)
            begin
                win_next[i] = byte_pop ? hw[i+1] : win_reg[i+1];
            end
            win_next[WINDOW_BYTES-1] = 8'd0;
            if (drain_pop)
            begin
                fill_next = fill_reg - IDX_W'(1);
                if (fill_reg == IDX_W'(1))
                    drain_next = 1'b0;
            end

            if (!in_frame_reg)
            begin
                // header search only with a full window
                if (byte_pop && hdr_hit)
                begin
                    in_frame_next      = 1'b1;
                    pos_next           = 33'd1;
                    total_next         = hdr_total;
                    plen_next          = pad_len;
                    hl_next            = hdr_hl;
                    type_next          = hdr_type;
                    time_next          = hdr_time;
                    res_valid          = 1'b1;
                    res.kind           = KIND_HDR;
                    res.media_type     = hdr_type;
                    res.media_time     = hdr_time;
                    res.payload_length = pad_len;
                    res.payload_byte   = 8'd0;
                    res.frame_last     = (pad_len == 33'd0);
                    res.run_last       = 1'b1;
                end
            end
            else
            begin
                res_valid          = (pos_reg >= {16'd0, hl_reg});
                res.kind           = KIND_PAYLOAD;
                res.media_type     = type_reg;
                res.media_time     = time_reg;
                res.payload_length = plen_reg;
                res.payload_byte   = win_reg[0];
                res.frame_last     = last_pos;
                res.run_last       = byte_pop ? 1'b1 : !more;
                if (last_pos)
                begin
                    in_frame_next = 1'b0;
                    pos_next      = 33'd0;
                end
                else
                begin
                    pos_next = pos_reg + 33'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            drain_reg    <= 1'b0;
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            total_reg    <= '0;
            plen_reg     <= '0;
            hl_reg       <= '0;
            type_reg     <= '0;
            time_reg     <= '0;
        end
        else
        begin
            fill_reg     <= fill_next;
            drain_reg    <= drain_next;
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            total_reg    <= total_next;
            plen_reg     <= plen_next;
            hl_reg       <= hl_next;
            type_reg     <= type_next;
            time_reg     <= time_next;
        end
    end

    // window bytes are only read once written
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    // output register plus one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (res_valid)
                out_reg <= res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign media_type     = out_reg.media_type;
    assign media_time     = out_reg.media_time;
    assign payload_length = out_reg.payload_length;
    assign payload_byte   = out_reg.payload_byte;
    assign frame_last     = out_reg.frame_last;
    assign run_last       = out_reg.run_last;

    // no new pop may start while a result sits in the skid entry
    `RFD_ASSERT_ALWAYS(a_skid_implies_out, !skid_valid_reg || out_valid_reg, "skid without head")
    `RFD_ASSERT_ALWAYS(a_drain_nonempty, !drain_reg || (fill_reg != '0), "drain on empty window")
    `RFD_ASSERT_ALWAYS(a_fill_bound, fill_reg <= LAST_IDX, "window fill overrun")
    `RFD_ASSERT_NEXT(a_drain_start, drain_acc && (fill_reg != '0), drain_reg, "drain not started")

endmodule
